// ----- hdl/lsrc_pkg.sv -----
// Shared codes, field widths and the microcode program of the light sensor calibrator.
`default_nettype none
package lsrc_pkg;

	// field widths
	localparam int LUX_W    = 16;
	localparam int ADC_W    = 12;
	localparam int MINPTS_W = 7;
	localparam int CFG_W    = 16;
	localparam int OUT_W    = 32;
	localparam int STEP_W   = 5;

	// default set capacity and register reset values
	localparam int DEF_MAX_POINTS = 100;
	localparam logic [MINPTS_W-1:0] MIN_POINTS_RST = 7'd3;
	localparam logic [LUX_W-1:0]    MIN_SPAN_RST   = 16'd30;

	// configuration register indexes
	localparam logic REG_MIN_POINTS   = 1'b0;
	localparam logic REG_MIN_LUX_SPAN = 1'b1;

	// request kinds
	typedef enum logic [1:0] {
		K_ADD     = 2'd0,
		K_CONVERT = 2'd1,
		K_CLEAR   = 2'd2
	} kind_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FEW  = 2'd1,
		ST_SPAN = 2'd2,
		ST_BAD  = 2'd3
	} status_t;

	// check flags from the calibration set
	typedef struct packed {
		logic few;
		logic span;
	} chk_t;

	// microcode fields
	typedef enum logic [2:0] {
		U_JMP      = 3'd0,
		U_MUL      = 3'd1,
		U_DIV      = 3'd2,
		U_RET_QUO  = 3'd3,
		U_RET_ZERO = 3'd4
	} uop_t;

	typedef enum logic [1:0] {
		C_FEW  = 2'd0,
		C_SPAN = 2'd1,
		C_BAD  = 2'd2,
		C_DEN0 = 2'd3
	} cond_t;

	typedef enum logic [2:0] {
		A_SXX = 3'd0,
		A_SX  = 3'd1,
		A_SXY = 3'd2,
		A_SY  = 3'd3,
		A_T   = 3'd4
	} asel_t;

	typedef enum logic [1:0] {
		B_N   = 2'd0,
		B_SX  = 2'd1,
		B_SY  = 2'd2,
		B_ADC = 2'd3
	} bsel_t;

	typedef enum logic [2:0] {
		W_DEN_LD  = 3'd0,
		W_DEN_SUB = 3'd1,
		W_T_LD    = 3'd2,
		W_T_SUB   = 3'd3,
		W_NUM_LD  = 3'd4,
		W_NUM_ADD = 3'd5,
		W_NUM_SUB = 3'd6
	} wop_t;

	typedef struct packed {
		uop_t              op;
		cond_t             cond;
		asel_t             a;
		bsel_t             b;
		wop_t              w;
		status_t           st;
		logic [STEP_W-1:0] target;
	} uword_t;

	// jump targets
	localparam logic [STEP_W-1:0] S_FAIL_FEW  = 5'd13;
	localparam logic [STEP_W-1:0] S_FAIL_SPAN = 5'd14;
	localparam logic [STEP_W-1:0] S_FAIL_BAD  = 5'd15;
	localparam logic [STEP_W-1:0] S_ZERO_DEN  = 5'd16;

	// conversion program:
	//   den = n*Sxx - Sx*Sx, t = n*Sxy - Sx*Sy,
	//   num = adc*t + Sy*Sxx - Sx*Sxy, lux = num / den
	function automatic uword_t ucode(input logic [STEP_W-1:0] step);
		uword_t w;
		w = '{op: U_RET_ZERO, cond: C_FEW, a: A_SXX, b: B_N, w: W_DEN_LD,
			st: ST_OK, target: '0};
		unique case (step)
			5'd0: begin
				w.op = U_JMP; w.cond = C_FEW; w.target = S_FAIL_FEW;
			end
			5'd1: begin
				w.op = U_JMP; w.cond = C_SPAN; w.target = S_FAIL_SPAN;
			end
			5'd2: begin
				w.op = U_JMP; w.cond = C_BAD; w.target = S_FAIL_BAD;
			end
			5'd3: begin
				w.op = U_MUL; w.a = A_SXX; w.b = B_N; w.w = W_DEN_LD;
			end
			5'd4: begin
				w.op = U_MUL; w.a = A_SX; w.b = B_SX; w.w = W_DEN_SUB;
			end
			5'd5: begin
				w.op = U_JMP; w.cond = C_DEN0; w.target = S_ZERO_DEN;
			end
			5'd6: begin
				w.op = U_MUL; w.a = A_SXY; w.b = B_N; w.w = W_T_LD;
			end
			5'd7: begin
				w.op = U_MUL; w.a = A_SY; w.b = B_SX; w.w = W_T_SUB;
			end
			5'd8: begin
				w.op = U_MUL; w.a = A_T; w.b = B_ADC; w.w = W_NUM_LD;
			end
			5'd9: begin
				w.op = U_MUL; w.a = A_SXX; w.b = B_SY; w.w = W_NUM_ADD;
			end
			5'd10: begin
				w.op = U_MUL; w.a = A_SXY; w.b = B_SX; w.w = W_NUM_SUB;
			end
			5'd11: begin
				w.op = U_DIV;
			end
			5'd12: begin
				w.op = U_RET_QUO;
			end
			5'd13: begin
				w.op = U_RET_ZERO; w.st = ST_FEW;
			end
			5'd14: begin
				w.op = U_RET_ZERO; w.st = ST_SPAN;
			end
			5'd15: begin
				w.op = U_RET_ZERO; w.st = ST_BAD;
			end
			5'd16: begin
				w.op = U_RET_ZERO; w.st = ST_OK;
			end
			default: begin
				w.op = U_RET_ZERO; w.st = ST_OK;
			end
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/light_sensor_regression_calibrator.sv -----
// Top level of the light sensor least-squares calibrator.
`default_nettype none
// Add and clear requests give no result. A convert request fits lux = m*adc + b
// over the stored pairs in exact integer arithmetic and returns one result (lux
// truncated toward zero and saturated to 32 bits, plus status). The conversion
// runs a 17-step microprogram: seven products go through a multiplier that takes
// eight bits of its narrow operand per cycle, and the quotient comes from a
// restoring divider that makes one bit per cycle over the full dividend width
// 2*clog2(MAX_POINTS+1)+42. A conversion rejected by a check, or one with a zero
// denominator, ends early with a zero result. A result that cannot leave holds
// the sequencer. No new request is taken while a conversion runs; a finished
// result waits in the output register without blocking input.
// Limit registers may be written at any time the block is idle.
module light_sensor_regression_calibrator #(
	parameter int MAX_POINTS = lsrc_pkg::DEF_MAX_POINTS
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// configuration writes
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire                              cfg_index,
	input  wire  [lsrc_pkg::CFG_W-1:0]       cfg_data,
	// requests
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire  [31:0]                      s_tdata,   // ref_lux[15:0], adc_sample[27:16]
	input  wire  [1:0]                       s_tuser,   // kind[1:0]
	// results
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [31:0]                      m_tdata,   // lux_out[31:0]
	output logic [1:0]                       m_tuser    // status[1:0]
);

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int SX_W  = CNT_W + 12;
	localparam int SXX_W = CNT_W + 24;
	localparam int SXY_W = CNT_W + 28;
	localparam int SY_W  = CNT_W + 16;

	logic                         accept;
	logic                         add_en;
	logic                         clr_en;
	logic                         start;
	logic [CNT_W-1:0]             cnt;
	logic [SX_W-1:0]              sx;
	logic [SXX_W-1:0]             sxx;
	logic [SXY_W-1:0]             sxy;
	logic [SY_W-1:0]              sy;
	lsrc_pkg::chk_t               chk;
	logic                         busy;
	logic                         done;
	logic                         out_free;
	logic [lsrc_pkg::OUT_W-1:0]   lux;
	lsrc_pkg::status_t            status;
	logic                         m_valid_q;
	logic [lsrc_pkg::OUT_W-1:0]   m_lux_q;
	logic [1:0]                   m_status_q;

	// decode an accepted request
	assign cfg_ready = 1'b1;
	assign s_tready  = !busy;
	assign accept    = s_tvalid && s_tready;
	assign add_en    = accept && (s_tuser == lsrc_pkg::K_ADD);
	assign clr_en    = accept && (s_tuser == lsrc_pkg::K_CLEAR);
	assign start     = accept && (s_tuser == lsrc_pkg::K_CONVERT);
	assign out_free  = !m_valid_q || m_tready;

	lsrc_calset #(
		.MAX_POINTS (MAX_POINTS)
	) u_calset (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.add_en    (add_en),
		.clr_en    (clr_en),
		.lux       (s_tdata[15:0]),
		.adc       (s_tdata[27:16]),
		.cnt       (cnt),
		.sx        (sx),
		.sxx       (sxx),
		.sxy       (sxy),
		.sy        (sy),
		.chk       (chk)
	);

	lsrc_seq #(
		.MAX_POINTS (MAX_POINTS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.adc      (s_tdata[27:16]),
		.cnt      (cnt),
		.sx       (sx),
		.sxx      (sxx),
		.sxy      (sxy),
		.sy       (sy),
		.chk      (chk),
		.out_free (out_free),
		.busy     (busy),
		.done     (done),
		.lux      (lux),
		.status   (status)
	);

	// hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (done)
			m_valid_q <= 1'b1;
		else if (m_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (done) begin
			m_lux_q    <= lux;
			m_status_q <= status;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_lux_q;
	assign m_tuser  = m_status_q;

endmodule
`default_nettype wire

// ----- hdl/lsrc_calset.sv -----
// Calibration set: running sums, count, lux extremes, limit registers and checks.
`default_nettype none
module lsrc_calset #(
	parameter int MAX_POINTS = lsrc_pkg::DEF_MAX_POINTS,
	localparam int CNT_W = $clog2(MAX_POINTS + 1),
	localparam int SX_W  = CNT_W + 12,
	localparam int SXX_W = CNT_W + 24,
	localparam int SXY_W = CNT_W + 28,
	localparam int SY_W  = CNT_W + 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire                              cfg_index,
	input  wire  [lsrc_pkg::CFG_W-1:0]       cfg_data,
	input  wire                              add_en,
	input  wire                              clr_en,
	input  wire  [lsrc_pkg::LUX_W-1:0]       lux,
	input  wire  [lsrc_pkg::ADC_W-1:0]       adc,
	output logic [CNT_W-1:0]                 cnt,
	output logic [SX_W-1:0]                  sx,
	output logic [SXX_W-1:0]                 sxx,
	output logic [SXY_W-1:0]                 sxy,
	output logic [SY_W-1:0]                  sy,
	output lsrc_pkg::chk_t                   chk
);

	localparam int CMP_W = (CNT_W > lsrc_pkg::MINPTS_W) ? CNT_W : lsrc_pkg::MINPTS_W;

	logic [lsrc_pkg::MINPTS_W-1:0] min_points_q;
	logic [lsrc_pkg::LUX_W-1:0]    min_span_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [SX_W-1:0]               sx_q;
	logic [SXX_W-1:0]              sxx_q;
	logic [SXY_W-1:0]              sxy_q;
	logic [SY_W-1:0]               sy_q;
	logic [lsrc_pkg::LUX_W-1:0]    lux_min_q;
	logic [lsrc_pkg::LUX_W-1:0]    lux_max_q;
	logic                          take;
	logic [2*lsrc_pkg::ADC_W-1:0]  adc_sq;
	logic [lsrc_pkg::ADC_W+lsrc_pkg::LUX_W-1:0] adc_lux;
	logic [lsrc_pkg::LUX_W-1:0]    span;

	// limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_points_q <= lsrc_pkg::MIN_POINTS_RST;
			min_span_q   <= lsrc_pkg::MIN_SPAN_RST;
		end else if (cfg_we) begin
			if (cfg_index == lsrc_pkg::REG_MIN_POINTS)
				min_points_q <= cfg_data[lsrc_pkg::MINPTS_W-1:0];
			else
				min_span_q <= cfg_data;
		end
	end

	// drop pairs once the set is full
	assign take    = add_en && (cnt_q != CNT_W'(MAX_POINTS));
	assign adc_sq  = adc * adc;
	assign adc_lux = adc * lux;

	// accumulate or clear the set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			sx_q      <= '0;
			sxx_q     <= '0;
			sxy_q     <= '0;
			sy_q      <= '0;
			lux_min_q <= '0;
			lux_max_q <= '0;
		end else if (clr_en) begin
			cnt_q     <= '0;
			sx_q      <= '0;
			sxx_q     <= '0;
			sxy_q     <= '0;
			sy_q      <= '0;
			lux_min_q <= '0;
			lux_max_q <= '0;
		end else if (take) begin
			cnt_q <= cnt_q + 1'b1;
			sx_q  <= sx_q + SX_W'(adc);
			sxx_q <= sxx_q + SXX_W'(adc_sq);
			sxy_q <= sxy_q + SXY_W'(adc_lux);
			sy_q  <= sy_q + SY_W'(lux);
			if (cnt_q == '0) begin
				lux_min_q <= lux;
				lux_max_q <= lux;
			end else begin
				if (lux > lux_max_q)
					lux_max_q <= lux;
				if (lux < lux_min_q)
					lux_min_q <= lux;
			end
		end
	end

	// conversion preconditions
	assign span     = lux_max_q - lux_min_q;
	assign chk.few  = CMP_W'(cnt_q) < CMP_W'(min_points_q);
	assign chk.span = span < min_span_q;

	assign cnt = cnt_q;
	assign sx  = sx_q;
	assign sxx = sxx_q;
	assign sxy = sxy_q;
	assign sy  = sy_q;

endmodule
`default_nettype wire

// ----- hdl/lsrc_mul.sv -----
// Signed by unsigned multiplier that consumes eight multiplier bits per cycle.
`default_nettype none
module lsrc_mul #(
	parameter int A_W = 56,
	parameter int B_W = 23
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              go,
	input  wire  [A_W-1:0]   a,
	input  wire  [B_W-1:0]   b,
	output logic             idle,
	output logic [A_W-1:0]   prod
);

	localparam int STEPS = (B_W + 7) / 8;
	localparam int CW    = $clog2(STEPS + 1);

	logic [CW-1:0]         cnt_q;
	logic [A_W-1:0]        a_q;
	logic [B_W-1:0]        b_q;
	logic [A_W-1:0]        prod_q;
	logic signed [A_W+8:0] pp;

	// partial product of the current byte
	assign pp = $signed(a_q) * $signed({1'b0, b_q[7:0]});

	// count slices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (go)
			cnt_q <= CW'(STEPS);
		else if (cnt_q != '0)
			cnt_q <= cnt_q - 1'b1;
	end

	// shift operands and accumulate
	always_ff @(posedge clk) begin
		if (go) begin
			a_q    <= a;
			b_q    <= b;
			prod_q <= '0;
		end else if (cnt_q != '0) begin
			a_q    <= a_q << 8;
			b_q    <= b_q >> 8;
			prod_q <= prod_q + pp[A_W-1:0];
		end
	end

	assign idle = (cnt_q == '0);
	assign prod = prod_q;

endmodule
`default_nettype wire

// ----- hdl/lsrc_div.sv -----
// Restoring divider of a signed dividend by a positive divisor, one quotient bit per cycle.
`default_nettype none
module lsrc_div #(
	parameter int N_W = 56,
	parameter int D_W = 38
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              go,
	input  wire  [N_W-1:0]   num,
	input  wire  [D_W-1:0]   den,
	output logic             idle,
	output logic             neg,
	output logic [N_W-1:0]   quo
);

	localparam int CW = $clog2(N_W + 1);

	logic [CW-1:0]  cnt_q;
	logic           neg_q;
	logic [N_W-1:0] q_q;
	logic [D_W-1:0] rem_q;
	logic [D_W-1:0] dvs_q;
	logic [D_W:0]   trial;
	logic           ge;

	// trial subtract of the divisor
	assign trial = {rem_q, q_q[N_W-1]} - {1'b0, dvs_q};
	assign ge    = !trial[D_W];

	// count quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (go)
			cnt_q <= CW'(N_W);
		else if (cnt_q != '0)
			cnt_q <= cnt_q - 1'b1;
	end

	// shift in one quotient bit
	always_ff @(posedge clk) begin
		if (go) begin
			neg_q <= num[N_W-1];
			q_q   <= num[N_W-1] ? (~num + 1'b1) : num;
			rem_q <= '0;
			dvs_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? trial[D_W-1:0] : {rem_q[D_W-2:0], q_q[N_W-1]};
			q_q   <= {q_q[N_W-2:0], ge};
		end
	end

	assign idle = (cnt_q == '0);
	assign neg  = neg_q;
	assign quo  = q_q;

endmodule
`default_nettype wire

// ----- hdl/lsrc_seq.sv -----
// Microcoded sequencer: step counter, program table, product registers, multiplier and divider.
`default_nettype none
module lsrc_seq #(
	parameter int MAX_POINTS = lsrc_pkg::DEF_MAX_POINTS,
	localparam int CNT_W = $clog2(MAX_POINTS + 1),
	localparam int SX_W  = CNT_W + 12,
	localparam int SXX_W = CNT_W + 24,
	localparam int SXY_W = CNT_W + 28,
	localparam int SY_W  = CNT_W + 16
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	input  wire  [lsrc_pkg::ADC_W-1:0]        adc,
	input  wire  [CNT_W-1:0]                  cnt,
	input  wire  [SX_W-1:0]                   sx,
	input  wire  [SXX_W-1:0]                  sxx,
	input  wire  [SXY_W-1:0]                  sxy,
	input  wire  [SY_W-1:0]                   sy,
	input  lsrc_pkg::chk_t                    chk,
	input  wire                               out_free,
	output logic                              busy,
	output logic                              done,
	output logic [lsrc_pkg::OUT_W-1:0]        lux,
	output lsrc_pkg::status_t                 status
);

	// datapath width holds num = adc*t + Sy*Sxx - Sx*Sxy with sign
	localparam int DW    = 2 * CNT_W + 42;
	localparam int DEN_W = 2 * CNT_W + 24;
	localparam int B_W   = SY_W;
	localparam logic [DW-1:0] POS_LIM = {{(DW-32){1'b0}}, 32'h7FFF_FFFF};
	localparam logic [DW-1:0] NEG_LIM = {{(DW-32){1'b0}}, 32'h8000_0000};

	logic                              busy_q;
	logic                              wait_q;
	logic [lsrc_pkg::STEP_W-1:0]       step_q;
	logic [lsrc_pkg::ADC_W-1:0]        adc_q;
	logic [DW-1:0]                     den_q;
	logic [DW-1:0]                     t_q;
	logic [DW-1:0]                     num_q;
	lsrc_pkg::uword_t                  uw;
	logic                              cond_hit;
	logic [DW-1:0]                     a_mux;
	logic [B_W-1:0]                    b_mux;
	logic                              mul_go;
	logic                              mul_idle;
	logic [DW-1:0]                     prod;
	logic                              mul_wb;
	logic                              div_go;
	logic                              div_idle;
	logic                              div_neg;
	logic [DW-1:0]                     quo;
	logic                              ret;
	logic [lsrc_pkg::OUT_W-1:0]        sat;

	assign uw = lsrc_pkg::ucode(step_q);

	// jump condition
	always_comb begin
		case (uw.cond)
			lsrc_pkg::C_FEW:  cond_hit = chk.few;
			lsrc_pkg::C_SPAN: cond_hit = chk.span;
			lsrc_pkg::C_BAD:  cond_hit = (adc_q == '0);
			lsrc_pkg::C_DEN0: cond_hit = (den_q == '0) || den_q[DW-1];
			default:          cond_hit = 1'b0;
		endcase
	end

	// multiplicand select
	always_comb begin
		case (uw.a)
			lsrc_pkg::A_SXX: a_mux = DW'(sxx);
			lsrc_pkg::A_SX:  a_mux = DW'(sx);
			lsrc_pkg::A_SXY: a_mux = DW'(sxy);
			lsrc_pkg::A_SY:  a_mux = DW'(sy);
			lsrc_pkg::A_T:   a_mux = t_q;
			default:         a_mux = '0;
		endcase
	end

	// multiplier select
	always_comb begin
		case (uw.b)
			lsrc_pkg::B_N:   b_mux = B_W'(cnt);
			lsrc_pkg::B_SX:  b_mux = B_W'(sx);
			lsrc_pkg::B_SY:  b_mux = sy;
			lsrc_pkg::B_ADC: b_mux = B_W'(adc_q);
			default:         b_mux = '0;
		endcase
	end

	assign mul_go = busy_q && (uw.op == lsrc_pkg::U_MUL) && !wait_q;
	assign mul_wb = busy_q && (uw.op == lsrc_pkg::U_MUL) && wait_q && mul_idle;
	assign div_go = busy_q && (uw.op == lsrc_pkg::U_DIV) && !wait_q;
	assign ret    = busy_q &&
		((uw.op == lsrc_pkg::U_RET_QUO) || (uw.op == lsrc_pkg::U_RET_ZERO));

	lsrc_mul #(
		.A_W (DW),
		.B_W (B_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go),
		.a      (a_mux),
		.b      (b_mux),
		.idle   (mul_idle),
		.prod   (prod)
	);

	lsrc_div #(
		.N_W (DW),
		.D_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (num_q),
		.den    (den_q[DEN_W-1:0]),
		.idle   (div_idle),
		.neg    (div_neg),
		.quo    (quo)
	);

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			wait_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			wait_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			unique case (uw.op)
				lsrc_pkg::U_JMP: begin
					step_q <= cond_hit ? uw.target : step_q + 1'b1;
				end
				lsrc_pkg::U_MUL: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (mul_idle) begin
						wait_q <= 1'b0;
						step_q <= step_q + 1'b1;
					end
				end
				lsrc_pkg::U_DIV: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (div_idle) begin
						wait_q <= 1'b0;
						step_q <= step_q + 1'b1;
					end
				end
				lsrc_pkg::U_RET_QUO, lsrc_pkg::U_RET_ZERO: begin
					if (out_free)
						busy_q <= 1'b0;
				end
				default: begin
					busy_q <= 1'b0;
				end
			endcase
		end
	end

	// write back products
	always_ff @(posedge clk) begin
		if (start)
			adc_q <= adc;
		if (mul_wb) begin
			case (uw.w)
				lsrc_pkg::W_DEN_LD:  den_q <= prod;
				lsrc_pkg::W_DEN_SUB: den_q <= den_q - prod;
				lsrc_pkg::W_T_LD:    t_q   <= prod;
				lsrc_pkg::W_T_SUB:   t_q   <= t_q - prod;
				lsrc_pkg::W_NUM_LD:  num_q <= prod;
				lsrc_pkg::W_NUM_ADD: num_q <= num_q + prod;
				lsrc_pkg::W_NUM_SUB: num_q <= num_q - prod;
				default:             num_q <= num_q;
			endcase
		end
	end

	// saturate quotient to the signed 32-bit range
	always_comb begin
		if (div_neg)
			sat = (quo > NEG_LIM) ? 32'h8000_0000 : (~quo[31:0] + 1'b1);
		else
			sat = (quo > POS_LIM) ? 32'h7FFF_FFFF : quo[31:0];
	end

	assign busy   = busy_q;
	assign done   = ret && out_free;
	assign lux    = (uw.op == lsrc_pkg::U_RET_QUO) ? sat : '0;
	assign status = (uw.op == lsrc_pkg::U_RET_QUO) ? lsrc_pkg::ST_OK : uw.st;

endmodule
`default_nettype wire
